[sv/date_add_days_core_macros.svh]
// Assertion macros for the date adder.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DATE_ADD_DAYS_CORE_MACROS_SVH
`define DATE_ADD_DAYS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dad_pkg.sv]
// Shared types, constants and calendar functions for the date adder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dad_pkg;

    localparam int ADD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [3:0] MONTHS    = 4'd12;
    localparam logic [4:0] FEB_DAYS  = 5'd28;
    localparam logic [4:0] MAX_DAY   = 5'd31;

    localparam logic signed [15:0] YEAR_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] YEAR_NEG1 = -16'sd1;
    localparam logic signed [15:0] YEAR_ONE  = 16'sd1;

    // Divisibility by 25 of a 16-bit value: multiply by the inverse of 25 mod 2^16;
    // the product lands at or below 65535/25 exactly for multiples of 25.
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_YEAR_ZERO   = 3'd1,
        ST_BAD_DAY     = 3'd2,
        ST_BAD_MONTH   = 3'd3,
        ST_DAY_PAST    = 3'd4,
        ST_FEB_NONLEAP = 3'd5,
        ST_FEB_OVER    = 3'd6,
        ST_OVERFLOW    = 3'd7
    } dad_status_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } dad_bstate_t;

    typedef struct packed {
        logic signed [15:0] start_year;
        logic [3:0]         start_month;
        logic [4:0]         start_day;
        logic [15:0]        days_to_add;
    } dad_req_t;

    typedef struct packed {
        logic signed [15:0] new_year;
        logic [3:0]         new_month;
        logic [4:0]         new_day;
        dad_status_t        status;
    } dad_rsp_t;

    // fin: result is complete; otherwise the item starts at day 1 of year/month.
    typedef struct packed {
        logic               fin;
        logic               leap;
        dad_status_t        status;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } dad_entry_t;

    // |y| divisible by 4 and not 100, or by 400 (400 = 16 * 25, 100 = 4 * 25).
    function automatic logic is_leap(input logic signed [15:0] y);
        logic [15:0] a;
        logic [15:0] p;
        logic        div25;
        a     = y[15] ? (~y + 16'd1) : y;
        p     = 16'(a * INV25);
        div25 = (p <= DIV25_MAX);
        return ((a[1:0] == 2'd0) && !div25) || ((a[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:    n = FEB_DAYS;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   n = MAX_DAY - 5'd1;
            default: n = MAX_DAY;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        return month_len(m) + {4'd0, (m == MONTH_FEB) && leap};
    endfunction

    function automatic logic signed [15:0] next_year(input logic signed [15:0] y);
        return (y == YEAR_NEG1) ? YEAR_ONE : (y + 16'sd1);
    endfunction

endpackage

`default_nettype wire

[sv/date_add_days_core.sv]
// Top level of the Gregorian date adder: front end, item queue, back end.
// Depends on dad_pkg, dad_front, dad_queue and dad_back.
//
//   channel   handshake          payload
//   request   start / busy       req  (dad_req_t)
//   result    done (strobe)      rsp  (dad_rsp_t)
//
// Front end: capture, leap check, date check; it holds one item at a time.
// Back end: pops an item, then steps one month per cycle with the single
// month/year stepper until the days fit, then strobes done.
// busy is high while the front end holds an item or the queue is full.
// Reset clears control state only; there is no clearing pass.
`default_nettype none

module date_add_days_core
    import dad_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire dad_req_t req,
    output logic          done,
    output dad_rsp_t      rsp
);

    logic                push;
    dad_entry_t          push_entry;
    logic [ADD_BITS-1:0] push_add;
    logic                pop;
    logic                empty;
    logic                full;
    dad_entry_t          head_entry;
    logic [ADD_BITS-1:0] head_add;

    dad_front #(
        .ADD_BITS (ADD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .full       (full),
        .push       (push),
        .push_entry (push_entry),
        .push_add   (push_add)
    );

    dad_queue #(
        .ADD_BITS (ADD_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_add   (push_add),
        .pop        (pop),
        .empty      (empty),
        .full       (full),
        .head_entry (head_entry),
        .head_add   (head_add)
    );

    dad_back #(
        .ADD_BITS (ADD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head_entry (head_entry),
        .head_add   (head_add),
        .pop        (pop),
        .done       (done),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

[sv/dad_front.sv]
// Front end: takes an item, checks the start date, completes it if the days
// fit, else moves it to day 1 of the next month. Depends on dad_pkg.
`default_nettype none

module dad_front
    import dad_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dad_req_t            req,
    input  wire logic                full,
    output logic                     push,
    output dad_entry_t               push_entry,
    output logic [ADD_BITS-1:0]      push_add
);

    logic       s1_v_reg, s1_v_next;
    logic       s2_v_reg, s2_v_next;
    dad_req_t   s1_req_reg;
    dad_req_t   s2_req_reg;
    logic       s2_leap_reg;
    logic       accept;

    logic signed [15:0]  y;
    logic [3:0]          m;
    logic [4:0]          d;
    logic [ADD_BITS-1:0] add;
    logic [4:0]          dim;
    logic [4:0]          left;

    assign busy   = s1_v_reg || s2_v_reg || full;
    assign accept = start && !busy;
    assign push   = s2_v_reg && !full;

    always_comb
    begin
        s1_v_next = accept;
        s2_v_next = s1_v_reg || (s2_v_reg && full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        if (s1_v_reg)
        begin
            s2_req_reg  <= s1_req_reg;
            s2_leap_reg <= is_leap(s1_req_reg.start_year);
        end
    end

    always_comb
    begin
        y    = s2_req_reg.start_year;
        m    = s2_req_reg.start_month;
        d    = s2_req_reg.start_day;
        add  = ADD_BITS'(s2_req_reg.days_to_add);
        dim  = days_in(m, s2_leap_reg);
        left = dim - d;

        push_entry      = '0;
        push_entry.fin  = 1'b1;
        push_entry.leap = s2_leap_reg;
        push_add        = '0;

        if (y == 16'sd0)
            push_entry.status = ST_YEAR_ZERO;
        else if (d == 5'd0)
            push_entry.status = ST_BAD_DAY;
        else if (m == 4'd0 || m > MONTHS)
            push_entry.status = ST_BAD_MONTH;
        else if (m != MONTH_FEB && d > month_len(m))
            push_entry.status = ST_DAY_PAST;
        else if (m == MONTH_FEB && d > FEB_DAYS && !s2_leap_reg)
            push_entry.status = ST_FEB_NONLEAP;
        else if (m == MONTH_FEB && d > (FEB_DAYS + 5'd1))
            push_entry.status = ST_FEB_OVER;
        else if (add <= ADD_BITS'(left))
        begin
            push_entry.year  = y;
            push_entry.month = m;
            push_entry.day   = d + add[4:0];
        end
        else
        begin
            push_add = add - ADD_BITS'(left) - ADD_BITS'(1);
            if (m == MONTH_DEC)
            begin
                if (y == YEAR_MAX)
                    push_entry.status = ST_OVERFLOW;
                else
                begin
                    push_entry.fin   = 1'b0;
                    push_entry.year  = next_year(y);
                    push_entry.month = MONTH_JAN;
                end
            end
            else
            begin
                push_entry.fin   = 1'b0;
                push_entry.year  = y;
                push_entry.month = m + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/dad_queue.sv]
// Short FIFO between front and back end, show-ahead read.
// Depends on dad_pkg.
`default_nettype none

module dad_queue
    import dad_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dad_entry_t          push_entry,
    input  wire logic [ADD_BITS-1:0] push_add,
    input  wire logic                pop,
    output logic                     empty,
    output logic                     full,
    output dad_entry_t               head_entry,
    output logic [ADD_BITS-1:0]      head_add
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dad_entry_t          entry_mem [QUEUE_DEPTH];
    logic [ADD_BITS-1:0] add_mem   [QUEUE_DEPTH];
    dad_entry_t          head_entry_reg;
    logic [ADD_BITS-1:0] head_add_reg;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty      = (count_reg == CNT_W'(0));
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_entry = head_entry_reg;
    assign head_add   = head_add_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head register holds the entry at the next read pointer; a write to that
    // slot in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
            add_mem[wr_ptr_reg]   <= push_add;
        end
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_entry_reg <= push_entry;
            head_add_reg   <= push_add;
        end
        else
        begin
            head_entry_reg <= entry_mem[rd_ptr_next];
            head_add_reg   <= add_mem[rd_ptr_next];
        end
    end

endmodule

`default_nettype wire

[sv/dad_back.sv]
// Back end: strobes finished items, steps others a month per cycle until
// days fit, then strobes. Depends on dad_pkg and the assertion macros.
`default_nettype none
`include "date_add_days_core_macros.svh"

module dad_back
    import dad_pkg::*;
#(
    parameter int ADD_BITS = ADD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire dad_entry_t          head_entry,
    input  wire logic [ADD_BITS-1:0] head_add,
    output logic                     pop,
    output logic                     done,
    output dad_rsp_t                 rsp
);

    dad_bstate_t         bstate_reg, bstate_next;
    logic signed [15:0]  year_reg,   year_next;
    logic [3:0]          month_reg,  month_next;
    logic [ADD_BITS-1:0] add_reg,    add_next;
    logic                leap_reg,   leap_next;
    logic                done_reg,   done_next;
    dad_rsp_t            rsp_reg,    rsp_next;
    logic [4:0]          dim;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        bstate_next = bstate_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        add_next    = add_reg;
        // leap flag lags the year by a register; January never reads it
        leap_next   = is_leap(year_reg);
        done_next   = 1'b0;
        rsp_next    = '0;
        pop         = 1'b0;
        dim         = days_in(month_reg, leap_reg);

        case (bstate_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head_entry.fin)
                    begin
                        done_next          = 1'b1;
                        rsp_next.new_year  = head_entry.year;
                        rsp_next.new_month = head_entry.month;
                        rsp_next.new_day   = head_entry.day;
                        rsp_next.status    = head_entry.status;
                    end
                    else
                    begin
                        bstate_next = B_RUN;
                        year_next   = head_entry.year;
                        month_next  = head_entry.month;
                        add_next    = head_add;
                        leap_next   = head_entry.leap;
                    end
                end
            end
            B_RUN:
            begin
                if (add_reg < ADD_BITS'(dim))
                begin
                    done_next          = 1'b1;
                    rsp_next.new_year  = year_reg;
                    rsp_next.new_month = month_reg;
                    rsp_next.new_day   = add_reg[4:0] + 5'd1;
                    rsp_next.status    = ST_OK;
                    bstate_next        = B_IDLE;
                end
                else
                begin
                    add_next = add_reg - ADD_BITS'(dim);
                    if (month_reg == MONTH_DEC)
                    begin
                        if (year_reg == YEAR_MAX)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_OVERFLOW;
                            bstate_next     = B_IDLE;
                        end
                        else
                        begin
                            month_next = MONTH_JAN;
                            year_next  = next_year(year_reg);
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg <= B_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            bstate_reg <= bstate_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        add_reg   <= add_next;
        leap_reg  <= leap_next;
        rsp_reg   <= rsp_next;
    end

    `DAD_ASSERT_IMP(a_err_zero, clk, rst_n, done_reg && rsp_reg.status != ST_OK, rsp_reg.new_year == 16'sd0 && rsp_reg.new_month == 4'd0 && rsp_reg.new_day == 5'd0, "error result carries a date")
    `DAD_ASSERT_IMP(a_ok_date, clk, rst_n, done_reg && rsp_reg.status == ST_OK, rsp_reg.new_year != 16'sd0 && rsp_reg.new_month != 4'd0 && rsp_reg.new_month <= MONTHS && rsp_reg.new_day != 5'd0, "ok result out of range")
    `DAD_ASSERT_NXT(a_add_drops, clk, rst_n, bstate_reg == B_RUN && bstate_next == B_RUN, add_reg < $past(add_reg), "month step did not consume days")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for date_add_days_core: start/busy request side, done strobe results.
// Predicts each date in-line with its own Gregorian stepper; depends only on dad_pkg and the RTL.
module tb;
    import dad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;
    localparam int CALM_TAIL   = 40;
    localparam int DRAIN_WAIT  = 50;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    dad_req_t req;
    logic     done;
    dad_rsp_t rsp;

    dad_req_t pending_items[$];
    dad_rsp_t expected_dates[$];
    int       error_count;
    int       items_accepted;
    int       item_total;
    int       gap_left;
    int       quiet_cycles;

    date_add_days_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit leap_of(int yr);
        int mag;
        mag = (yr < 0) ? -yr : yr;
        return ((mag % 4 == 0) && (mag % 100 != 0)) || (mag % 400 == 0);
    endfunction

    function automatic int month_days(int mo, int yr);
        int n;
        case (mo)
            2:         n = leap_of(yr) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:   n = 31;
        endcase
        return n;
    endfunction

    function automatic dad_rsp_t predict_date(dad_req_t item);
        dad_rsp_t r;
        int       yr;
        int       mo;
        int       dy;
        int       remain;
        int       left;
        bit       stepping;
        r      = '0;
        r.status = ST_OK;
        yr     = int'($signed(item.start_year));
        mo     = int'(item.start_month);
        dy     = int'(item.start_day);
        remain = int'(item.days_to_add);
        if (yr == 0)
            r.status = ST_YEAR_ZERO;
        else if (dy == 0)
            r.status = ST_BAD_DAY;
        else if (mo == 0 || mo > 12)
            r.status = ST_BAD_MONTH;
        else if (mo != MONTH_FEB && dy > month_days(mo, yr))
            r.status = ST_DAY_PAST;
        else if (mo == MONTH_FEB && dy > 28 && !leap_of(yr))
            r.status = ST_FEB_NONLEAP;
        else if (mo == MONTH_FEB && dy > 29)
            r.status = ST_FEB_OVER;
        else
        begin
            left = month_days(mo, yr) - dy;
            if (remain <= left)
                dy = dy + remain;
            else
            begin
                // day 1 of next month, then whole months; no year zero
                remain   = remain - (left + 1);
                stepping = 1'b1;
                while (stepping)
                begin
                    if (mo == MONTH_DEC)
                    begin
                        mo = 1;
                        yr = (yr == -1) ? 1 : yr + 1;
                    end
                    else
                        mo = mo + 1;
                    if (yr > 32767)
                        stepping = 1'b0;
                    else if (remain < month_days(mo, yr))
                        stepping = 1'b0;
                    else
                        remain = remain - month_days(mo, yr);
                end
                dy = remain + 1;
            end
            if (yr > 32767)
                r.status = ST_OVERFLOW;
            else
            begin
                r.new_year  = 16'(yr);
                r.new_month = 4'(mo);
                r.new_day   = 5'(dy);
            end
        end
        return r;
    endfunction

    function automatic dad_req_t make_req(int yr, int mo, int dy, int add);
        dad_req_t r;
        r.start_year  = 16'(yr);
        r.start_month = 4'(mo);
        r.start_day   = 5'(dy);
        r.days_to_add = 16'(add);
        return r;
    endfunction

    function automatic dad_req_t random_req();
        return make_req($urandom_range(0, 65535), $urandom_range(0, 15),
                        $urandom_range(0, 31), $urandom_range(0, 65535));
    endfunction

    function automatic int random_year();
        int yr;
        case ($urandom_range(0, 5))
            0:       yr = $urandom_range(1, 3) * (($urandom_range(0, 1) == 1) ? -1 : 1);
            1:       yr = $urandom_range(32755, 32767);
            2:       yr = -$urandom_range(32755, 32768);
            3:       yr = $urandom_range(1, 327) * 100 * (($urandom_range(0, 1) == 1) ? -1 : 1);
            4:       yr = $urandom_range(1890, 2110);
            default: yr = int'($signed(16'($urandom_range(0, 65535))));
        endcase
        if (yr == 0)
            yr = 1;
        return yr;
    endfunction

    function automatic dad_req_t random_date_item();
        int yr;
        int mo;
        int dy;
        int add;
        int left;
        int pick;
        yr   = random_year();
        mo   = $urandom_range(1, 12);
        dy   = $urandom_range(1, month_days(mo, yr));
        left = month_days(mo, yr) - dy;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            add = $urandom_range(0, 400);
        else if (pick < 75)
            add = left + $urandom_range(0, 2) - 1;
        else if (pick < 90)
            add = $urandom_range(0, 4000);
        else
            add = $urandom_range(0, 65535);
        if (add < 0)
            add = 0;
        return make_req(yr, mo, dy, add);
    endfunction

    function automatic dad_req_t broken_date_item();
        dad_req_t r;
        int       yr;
        int       mo;
        r  = random_date_item();
        yr = int'($signed(r.start_year));
        mo = int'(r.start_month);
        case ($urandom_range(0, 4))
            0: r.start_year = '0;
            1: r.start_day = '0;
            2: r.start_month = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(13, 15));
            3:
            begin
                if (mo == MONTH_FEB || month_days(mo, yr) == 31)
                    r.start_month = 4'd4;
                r.start_day = 5'($urandom_range(31, 31));
            end
            default:
            begin
                r.start_month = MONTH_FEB;
                r.start_day   = 5'($urandom_range(29, 31));
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count = error_count + 1;
        $display("%0t: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_dates.push_back(predict_date(req));
                void'(pending_items.pop_front());
                items_accepted = items_accepted + 1;
                if (items_accepted < item_total - CALM_TAIL && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 11);
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
                req   <= random_req();
            end
            else if (pending_items.size() > 0)
            begin
                start <= 1'b1;
                req   <= pending_items[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_dates.size() == 0)
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
                    $signed(rsp.new_year), rsp.new_month, rsp.new_day, rsp.status));
            else
            begin
                dad_rsp_t want;
                want = expected_dates.pop_front();
                if (rsp.new_year != want.new_year || rsp.new_month != want.new_month ||
                    rsp.new_day != want.new_day || rsp.status != want.status)
                    report_mismatch($sformatf(
                        "got %0d-%0d-%0d status %0d, want %0d-%0d-%0d status %0d",
                        $signed(rsp.new_year), rsp.new_month, rsp.new_day, rsp.status,
                        $signed(want.new_year), want.new_month, want.new_day, want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int pick;
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        error_count    = 0;
        items_accepted = 0;
        gap_left       = 0;
        quiet_cycles   = 0;

        // invalid dates, in check order
        pending_items.push_back(make_req(0, 15, 0, 100));
        pending_items.push_back(make_req(2023, 14, 0, 5));
        pending_items.push_back(make_req(2023, 0, 12, 5));
        pending_items.push_back(make_req(2023, 13, 1, 0));
        pending_items.push_back(make_req(2023, 15, 31, 0));
        pending_items.push_back(make_req(2023, 4, 31, 1));
        pending_items.push_back(make_req(-7, 6, 31, 65535));
        pending_items.push_back(make_req(2023, 2, 29, 0));
        pending_items.push_back(make_req(-1900, 2, 29, 3));
        pending_items.push_back(make_req(2024, 2, 30, 0));
        pending_items.push_back(make_req(2000, 2, 31, 1));
        // leap February, exact fits, year step over zero
        pending_items.push_back(make_req(2024, 2, 29, 0));
        pending_items.push_back(make_req(2024, 2, 28, 1));
        pending_items.push_back(make_req(-2000, 2, 29, 1));
        pending_items.push_back(make_req(2100, 2, 28, 1));
        pending_items.push_back(make_req(2023, 1, 1, 30));
        pending_items.push_back(make_req(-4, 2, 1, 28));
        pending_items.push_back(make_req(2023, 4, 15, 15));
        pending_items.push_back(make_req(-1, 12, 31, 1));
        pending_items.push_back(make_req(-2, 11, 30, 400));
        // extremes and overflow
        pending_items.push_back(make_req(32767, 12, 31, 0));
        pending_items.push_back(make_req(32767, 12, 31, 1));
        pending_items.push_back(make_req(32767, 1, 1, 65535));
        pending_items.push_back(make_req(-32768, 1, 1, 65535));
        pending_items.push_back(make_req(2000, 1, 1, 65535));

        for (k = 0; k < 245; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                pending_items.push_back(random_date_item());
            else if (pick < 87)
                pending_items.push_back(broken_date_item());
            else
                pending_items.push_back(random_req());
        end
        item_total = pending_items.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[date_add_days_core.f]
+incdir+sv
sv/dad_pkg.sv
sv/dad_front.sv
sv/dad_queue.sv
sv/dad_back.sv
sv/date_add_days_core.sv
tb/tb.sv
